// File: rtl/sorted_timer_expiry_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted timer expiry queue
// Shared same-cycle and next-cycle implication checks on i_clk.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_EXPIRY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_TIMER_EXPIRY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define STQ_ASSERT_IMP(label, a, b, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication
`define STQ_ASSERT_NXT(label, a, b, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// File: rtl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Types and constants of the sorted timer expiry queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int HND_W   = 8;
    localparam int TIME_W  = 32;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_ADJUST = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_EXPIRED = 2'd0,
        ST_REJECT  = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    typedef struct packed {
        t_mode              mode;
        logic [HND_W-1:0]   handle;
        logic [TIME_W-1:0]  expiry;
        logic [TIME_W-1:0]  now_time;
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REMOVE,
        S_INSERT,
        S_TICK
    } t_state;

endpackage

`default_nettype wire

// File: rtl/stq_front.sv
// ----------------------------------------------------------------------------
// stq_front
// Two-entry request queue between the input channel and the table sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire stq_pkg::t_req i_req,
    output logic               o_req_valid,
    output stq_pkg::t_req      o_req,
    input  wire logic          i_pop
);

    stq_pkg::t_req r_buf [2];
    logic          r_wr_ptr, r_rd_ptr;
    logic [1:0]    r_fill;
    logic          push, pop;

    assign o_in_stall  = (r_fill == 2'd2);
    assign push        = i_in_valid && !o_in_stall;
    assign o_req_valid = (r_fill != 2'd0);
    assign pop         = i_pop && o_req_valid;
    assign o_req       = r_buf[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= !r_wr_ptr;
            if (pop)  r_rd_ptr <= !r_rd_ptr;
            r_fill <= r_fill + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_buf[r_wr_ptr] <= i_req;
    end

endmodule

`default_nettype wire

// File: rtl/stq_back.sv
// ----------------------------------------------------------------------------
// stq_back
// Sorted timer table with its sequencer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_timer_expiry_queue_unit_defines.svh"

module stq_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    input  wire stq_pkg::t_req               i_req,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [stq_pkg::HND_W-1:0]        o_out_handle,
    output logic [1:0]                       o_status,
    output logic                             o_last
);

    localparam int D = stq_pkg::DEPTH;

    stq_pkg::t_state             r_state, n_state;
    stq_pkg::t_req               r_req;
    logic [stq_pkg::TIME_W-1:0]  r_exp [D];
    logic [stq_pkg::HND_W-1:0]   r_hnd [D];
    logic [stq_pkg::CNT_W-1:0]   r_count;
    logic                        r_out_valid;
    logic [stq_pkg::HND_W-1:0]   r_out_handle;
    stq_pkg::t_status            r_status;
    logic                        r_last;

    logic [D-1:0] vld, match, lt, pre;
    logic         found, full, out_free, expired, tick_last;
    logic         ins_en, rem_en, shl_all, emit;
    stq_pkg::t_status emit_status;
    logic         emit_last;
    logic [stq_pkg::HND_W-1:0] emit_handle;

    always_comb begin
        for (int i = 0; i < D; i++) begin
            vld[i]   = (stq_pkg::CNT_W'(i) < r_count);
            match[i] = vld[i] && (r_hnd[i] == r_req.handle);
            lt[i]    = vld[i] && (r_exp[i] <= r_req.expiry);
        end
        pre[0] = match[0];
        for (int i = 1; i < D; i++) pre[i] = pre[i-1] | match[i];
    end

    assign found     = |match;
    assign full      = (r_count == stq_pkg::CNT_W'(D));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign expired   = (r_count != '0) && (r_req.now_time >= r_exp[0]);
    assign tick_last = (r_count == stq_pkg::CNT_W'(1)) || (r_req.now_time < r_exp[1]);

    // outputs of the sequencer
    always_comb begin
        o_pop       = 1'b0;
        ins_en      = 1'b0;
        rem_en      = 1'b0;
        shl_all     = 1'b0;
        emit        = 1'b0;
        emit_status = stq_pkg::ST_EXPIRED;
        emit_last   = 1'b1;
        emit_handle = r_req.handle;
        unique case (r_state)
            stq_pkg::S_IDLE:   o_pop = i_req_valid;
            stq_pkg::S_ADD: begin
                if (full || found) begin
                    emit        = out_free;
                    emit_status = stq_pkg::ST_REJECT;
                end else begin
                    ins_en = 1'b1;
                end
            end
            stq_pkg::S_REMOVE: begin
                if (!found) begin
                    emit        = out_free;
                    emit_status = stq_pkg::ST_UNKNOWN;
                end else begin
                    rem_en = 1'b1;
                end
            end
            stq_pkg::S_INSERT: ins_en = 1'b1;
            stq_pkg::S_TICK: begin
                if (expired && out_free) begin
                    emit        = 1'b1;
                    shl_all     = 1'b1;
                    emit_handle = r_hnd[0];
                    emit_last   = tick_last;
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stq_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req.mode)
                        stq_pkg::MODE_ADD:  n_state = stq_pkg::S_ADD;
                        stq_pkg::MODE_TICK: n_state = stq_pkg::S_TICK;
                        default:            n_state = stq_pkg::S_REMOVE;
                    endcase
                end
            end
            stq_pkg::S_ADD:    if (ins_en || emit) n_state = stq_pkg::S_IDLE;
            stq_pkg::S_REMOVE: begin
                if (rem_en)
                    n_state = (r_req.mode == stq_pkg::MODE_ADJUST) ?
                              stq_pkg::S_INSERT : stq_pkg::S_IDLE;
                else if (emit)
                    n_state = stq_pkg::S_IDLE;
            end
            stq_pkg::S_INSERT: n_state = stq_pkg::S_IDLE;
            stq_pkg::S_TICK:   if (!expired || (emit && emit_last)) n_state = stq_pkg::S_IDLE;
            default:           n_state = stq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ins_en)
                r_count <= r_count + stq_pkg::CNT_W'(1);
            else if (rem_en || shl_all)
                r_count <= r_count - stq_pkg::CNT_W'(1);
            if (emit)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_req <= i_req;
        if (emit) begin
            r_out_handle <= emit_handle;
            r_status     <= emit_status;
            r_last       <= emit_last;
        end
        for (int i = 0; i < D; i++) begin
            if (ins_en && !lt[i]) begin
                // place the new timer after every entry not later than it
                if (i == 0 || lt[(i > 0) ? i-1 : 0]) begin
                    r_exp[i] <= r_req.expiry;
                    r_hnd[i] <= r_req.handle;
                end else begin
                    r_exp[i] <= r_exp[(i > 0) ? i-1 : 0];
                    r_hnd[i] <= r_hnd[(i > 0) ? i-1 : 0];
                end
            end else if ((rem_en && pre[i]) || shl_all) begin
                if (i < D-1) begin
                    r_exp[i] <= r_exp[(i < D-1) ? i+1 : i];
                    r_hnd[i] <= r_hnd[(i < D-1) ? i+1 : i];
                end
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_handle = r_out_handle;
    assign o_status     = r_status;
    assign o_last       = r_last;

    `STQ_ASSERT_IMP(a_count_bound, 1'b1, r_count <= stq_pkg::CNT_W'(D), "entry count above depth")
    `STQ_ASSERT_NXT(a_ins_count, ins_en, r_count == $past(r_count) + stq_pkg::CNT_W'(1), "insert lost")
    `STQ_ASSERT_IMP(a_no_ins_full, ins_en, !full, "insert into full table")
    `STQ_ASSERT_IMP(a_tick_status, shl_all, emit_status == stq_pkg::ST_EXPIRED, "tick status wrong")

endmodule

`default_nettype wire

// File: rtl/sorted_timer_expiry_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_timer_expiry_queue_unit
// Timer queue sorted by expiry: add, adjust, delete and tick requests.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                Payload
// in       input      i_in_valid / o_in_stall  i_mode i_handle i_expiry i_now_time
// out      output     o_out_valid / i_out_stall o_out_handle o_status o_last
//
// Add and delete pass through the add or remove state of the sequencer, adjust
// through remove then insert; a tick retires expired timers in order, each as the output is free.
// A two-entry request queue lets requests arrive while the sequencer works.
// Reset is synchronous and empties the table; cell contents are not cleared.
// A stalled result holds the sequencer only when it has another to deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timer_expiry_queue_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_mode,
    input  wire logic [stq_pkg::HND_W-1:0]   i_handle,
    input  wire logic [stq_pkg::TIME_W-1:0]  i_expiry,
    input  wire logic [stq_pkg::TIME_W-1:0]  i_now_time,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [stq_pkg::HND_W-1:0]        o_out_handle,
    output logic [1:0]                       o_status,
    output logic                             o_last
);

    stq_pkg::t_req in_req, q_req;
    logic          q_valid, q_pop;

    always_comb begin
        in_req.mode     = stq_pkg::t_mode'(i_mode);
        in_req.handle   = i_handle;
        in_req.expiry   = i_expiry;
        in_req.now_time = i_now_time;
    end

    stq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (in_req),
        .o_req_valid (q_valid),
        .o_req       (q_req),
        .i_pop       (q_pop)
    );

    stq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (q_valid),
        .i_req        (q_req),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_handle (o_out_handle),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// File: dv/sorted_timer_expiry_queue_unit_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the sorted timer expiry queue
// Drives add, adjust, delete and tick requests with random gaps and output
// stalls, predicts every result from a local copy of the timer table and
// checks each result field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module sorted_timer_expiry_queue_unit_tb;

    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic [stq_pkg::HND_W-1:0] handle;
        stq_pkg::t_status          status;
        logic                      last;
    } t_expiry_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [1:0]                   i_mode = '0;
    logic [stq_pkg::HND_W-1:0]    i_handle = '0;
    logic [stq_pkg::TIME_W-1:0]   i_expiry = '0;
    logic [stq_pkg::TIME_W-1:0]   i_now_time = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [stq_pkg::HND_W-1:0]    o_out_handle;
    logic [1:0]                   o_status;
    logic                         o_last;

    // local copy of the timer table
    logic [stq_pkg::TIME_W-1:0]   tbl_expiry[stq_pkg::DEPTH];
    logic [stq_pkg::HND_W-1:0]    tbl_handle[stq_pkg::DEPTH];
    int                           tbl_count = 0;

    t_expiry_result      pending_results[$];
    int                  mismatches = 0;
    int                  cycles = 0;
    bit                  hold_receiver = 1'b0;
    bit                  no_idle = 1'b0;

    sorted_timer_expiry_queue_unit DUT (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int find_timer(logic [stq_pkg::HND_W-1:0] h);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_handle[i] == h) return i;
        return -1;
    endfunction

    function automatic void drop_timer(int pos);
        for (int i = pos; i + 1 < tbl_count; i++) begin
            tbl_expiry[i] = tbl_expiry[i+1];
            tbl_handle[i] = tbl_handle[i+1];
        end
        tbl_count--;
    endfunction

    function automatic void place_timer(logic [stq_pkg::HND_W-1:0] h,
                                        logic [stq_pkg::TIME_W-1:0] e);
        int pos;
        pos = 0;
        while (pos < tbl_count && tbl_expiry[pos] <= e) pos++;
        for (int i = tbl_count; i > pos; i--) begin
            tbl_expiry[i] = tbl_expiry[i-1];
            tbl_handle[i] = tbl_handle[i-1];
        end
        tbl_expiry[pos] = e;
        tbl_handle[pos] = h;
        tbl_count++;
    endfunction

    function automatic void predict_request(stq_pkg::t_mode m, logic [stq_pkg::HND_W-1:0] h,
                                            logic [stq_pkg::TIME_W-1:0] e,
                                            logic [stq_pkg::TIME_W-1:0] now);
        int pos;
        int n;
        n = 0;
        case (m)
            stq_pkg::MODE_ADD: begin
                if (tbl_count >= stq_pkg::DEPTH || find_timer(h) >= 0)
                    pending_results.push_back('{h, stq_pkg::ST_REJECT, 1'b1});
                else
                    place_timer(h, e);
            end
            stq_pkg::MODE_ADJUST, stq_pkg::MODE_DELETE: begin
                pos = find_timer(h);
                if (pos < 0) begin
                    pending_results.push_back('{h, stq_pkg::ST_UNKNOWN, 1'b1});
                end else begin
                    drop_timer(pos);
                    if (m == stq_pkg::MODE_ADJUST) place_timer(h, e);
                end
            end
            default: begin
                while (tbl_count > 0 && now >= tbl_expiry[0]) begin
                    pending_results.push_back('{tbl_handle[0], stq_pkg::ST_EXPIRED, 1'b0});
                    drop_timer(0);
                    n++;
                end
                if (n > 0) pending_results[$].last = 1'b1;
            end
        endcase
    endfunction

    // offer one request, hold it until accepted, then idle for a random gap (possibly none) before the next
    task automatic send_request(stq_pkg::t_mode m, logic [stq_pkg::HND_W-1:0] h,
                                logic [stq_pkg::TIME_W-1:0] e,
                                logic [stq_pkg::TIME_W-1:0] now);
        int gap;
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_handle   <= h;
        i_expiry   <= e;
        i_now_time <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(m, h, e, now);
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // receiver stall: a drawn wait before each result, or held off while hold_receiver is set
    initial begin
        int gap;
        forever begin
            if (hold_receiver) begin
                i_out_stall <= 1'b1;
                @(posedge i_clk);
            end else begin
                gap = no_idle ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                do @(posedge i_clk);
                while (!(o_out_valid && !i_out_stall) && !hold_receiver);
            end
        end
    end

    always @(posedge i_clk) begin
        t_expiry_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result handle %0d status %0d last %0d",
                             o_out_handle, o_status, o_last);
            end else begin
                want = pending_results.pop_front();
                if (o_out_handle !== want.handle || o_status !== want.status
                    || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected h=%0d st=%0d l=%0d got h=%0d st=%0d l=%0d",
                                 want.handle, want.status, want.last,
                                 o_out_handle, o_status, o_last);
                end
            end
        end
    end

    task automatic test_directed();
        send_request(stq_pkg::MODE_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);      // empty tick
        send_request(stq_pkg::MODE_DELETE, 8'd7, 32'd0, 32'd0);            // unknown delete
        send_request(stq_pkg::MODE_ADJUST, 8'hFF, 32'd5, 32'd0);           // unknown adjust
        send_request(stq_pkg::MODE_ADD, 8'd0, 32'hFFFF_FFFF, 32'd0);
        send_request(stq_pkg::MODE_ADD, 8'hFF, 32'd0, 32'hFFFF_FFFF);
        send_request(stq_pkg::MODE_ADD, 8'd5, 32'd100, 32'd0);
        send_request(stq_pkg::MODE_ADD, 8'd6, 32'd100, 32'd0);             // equal expiry
        send_request(stq_pkg::MODE_ADD, 8'd5, 32'd1, 32'd0);               // duplicate
        send_request(stq_pkg::MODE_ADJUST, 8'd6, 32'd50, 32'd0);           // earlier
        send_request(stq_pkg::MODE_ADJUST, 8'hFF, 32'd200, 32'd0);         // later
        send_request(stq_pkg::MODE_TICK, 8'hAA, 32'hFFFF_FFFF, 32'd99);
        send_request(stq_pkg::MODE_DELETE, 8'd5, 32'd0, 32'd0);
        send_request(stq_pkg::MODE_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);      // drains all
        for (int i = 0; i < stq_pkg::DEPTH; i++)
            send_request(stq_pkg::MODE_ADD, 8'(i + 16), 32'(i), 32'd0);
        send_request(stq_pkg::MODE_ADD, 8'd99, 32'd3, 32'd0);              // full table
        send_request(stq_pkg::MODE_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);      // sixteen expire
        wait_drained();
    endtask

    task automatic send_random(int count);
        int roll;
        logic [stq_pkg::HND_W-1:0] h;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 9);
            // mostly a small pool of handles so adjusts and deletes hit
            h = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23));
            if (roll < 4)
                send_request(stq_pkg::MODE_ADD, h, ($urandom_range(0, 5) == 0) ? $urandom
                             : 32'($urandom_range(0, 300)), $urandom);
            else if (roll < 6)
                send_request(stq_pkg::MODE_ADJUST, h, ($urandom_range(0, 5) == 0) ? $urandom
                             : 32'($urandom_range(0, 300)), $urandom);
            else if (roll < 8)
                send_request(stq_pkg::MODE_DELETE, h, $urandom, $urandom);
            else
                send_request(stq_pkg::MODE_TICK, 8'($urandom), $urandom,
                             ($urandom_range(0, 5) == 0) ? $urandom
                             : 32'($urandom_range(0, 300)));
        end
    endtask

    task automatic test_random();
        send_random(160);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // hold the receiver off so the request queue fills and stalls input
        fork
            begin
                hold_receiver = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
        join_none
        no_idle = 1'b1;
        for (int i = 0; i < 6; i++)
            send_request(stq_pkg::MODE_DELETE, 8'(200 + i), 32'd0, 32'd0);
        send_request(stq_pkg::MODE_ADD, 8'd1, 32'd1, 32'd0);
        send_request(stq_pkg::MODE_ADD, 8'd2, 32'd2, 32'd0);
        send_request(stq_pkg::MODE_TICK, 8'd0, 32'd0, 32'hFFFF_FFFF);
        no_idle = 1'b0;
        wait_drained();
        send_random(30);
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_backpressure();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
